// ===== rtl/ipt_pkg.sv =====
package ipt_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int KEY_W      = 32;
   localparam int LEN_W      = 6;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 11;
   localparam int FUNC_W     = 2;
   localparam int STAT_W     = 2;
   localparam int MAX_LEN    = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_DUP  = 2'd3
   } status_type;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [IDX_W-1:0] parent;
      logic             holds;
      logic [VAL_W-1:0] value;
   } node_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_INS_WALK,
      S_INS_ALLOC,
      S_INS_POP,
      S_INS_LINK,
      S_INS_FINAL,
      S_DEL_WALK,
      S_DEL_CHECK,
      S_PRUNE_UP,
      S_PRUNE_FREE
   } fsm_type;

endpackage

// ===== rtl/ipt_node_mem.sv =====
module ipt_node_mem (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ipt_pkg::IDX_W-1:0] wr_addr,
   input  ipt_pkg::node_type       wr_data,
   input  logic                    rd_en,
   input  logic [ipt_pkg::IDX_W-1:0] rd_addr,
   output ipt_pkg::node_type       rd_data
);
   import ipt_pkg::*;

   node_type mem [NODE_COUNT];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ipv4_prefix_trie_unit.sv =====
// Binary trie for IPv4 longest prefix match. Each request transfer carries an
// operation in req_tuser (insert, delete or lookup) and a key, a prefix length and a
// value in req_tdata; each one produces exactly one response transfer with a status,
// a found flag, the matched value and the number of stored prefixes. The root node
// lives in flip-flops and all other nodes in a single-port-write, single-port-read
// node memory with a registered read, which is the unit that paces the block: a
// lookup reads one node per trie level visited (up to 33), an insert walks the
// existing levels and then allocates and links each node it creates (with an extra
// step when the node comes off the free list), and a delete walks the levels and
// then unlinks and frees each pruned node. The block takes one operation at a
// time; req_tready is high only when no operation is in flight and the response
// register is empty. Nodes freed by delete are chained through their right link and
// reused first. Lengths above 32 are treated as 32, and the unused operation code
// answers not found and changes nothing. No clearing pass is needed after reset.
module ipv4_prefix_trie_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // func
   input  logic [71:0] req_tdata,  // key[31:0], prefix_len[37:32], entry_value[69:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // status[1:0], found[2], found_value[34:3],
                                   // prefix_count[45:35]
);
   import ipt_pkg::*;

   // Control state.
   fsm_type state_ff, state_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W:0]   next_unused_ff, next_unused_in;
   logic [CNT_W-1:0] count_ff, count_in;
   node_type         root_ff, root_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Operation working registers.
   logic [KEY_W-1:0] key_ff, key_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0] depth_ff, depth_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] par_idx_ff, par_idx_in;
   logic [IDX_W-1:0] up_idx_ff, up_idx_in;
   logic [IDX_W-1:0] new_idx_ff, new_idx_in;
   node_type         par_ff, par_in;
   node_type         up_ff, up_in;
   logic             found_ff, found_in;
   logic [VAL_W-1:0] fval_ff, fval_in;

   // Response register.
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Node access.
   logic             wr_req;
   logic [IDX_W-1:0] wr_idx;
   node_type         wr_rec;
   logic             mem_wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   node_type         rd_data;
   node_type         view;
   node_type         up_view;
   logic [IDX_W-1:0] child;
   logic             accept;
   logic [LEN_W-1:0] req_len;
   logic             has_free;
   logic             has_unused;
   logic             up_stops;
   logic             found_now;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_len    = (req_tdata[37:32] > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                            : req_tdata[37:32];

   // The node under the walk is the root register or the last memory read.
   assign view    = (idx_ff == '0) ? root_ff : rd_data;
   assign up_view = (up_idx_ff == '0) ? root_ff : rd_data;
   assign child   = key_ff[KEY_W-1] ? view.right : view.left;
   assign has_free   = (free_head_ff != '0);
   assign has_unused = (next_unused_ff < (IDX_W+1)'(NODE_COUNT));
   assign up_stops   = (up_idx_ff == '0) || (up_ff.left != '0) || (up_ff.right != '0) ||
                       up_ff.holds;
   assign found_now  = found_ff || view.holds;

   ipt_node_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mem_wr_en = wr_req && (wr_idx != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_tuser))
                  FUNC_INSERT: state_in = S_INS_WALK;
                  FUNC_DELETE: state_in = S_DEL_WALK;
                  FUNC_LOOKUP: state_in = S_LOOKUP;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_LOOKUP: begin
            if (depth_ff == LEN_W'(MAX_LEN) || child == '0) begin
               state_in = S_IDLE;
            end
         end
         S_INS_WALK: begin
            if (len_ff == '0) begin
               state_in = S_INS_FINAL;
            end else if (child == '0) begin
               state_in = S_INS_ALLOC;
            end
         end
         S_INS_ALLOC: begin
            if (has_free) begin
               state_in = S_INS_POP;
            end else if (has_unused) begin
               state_in = S_INS_LINK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INS_POP:   state_in = S_INS_LINK;
         S_INS_LINK:  state_in = (len_ff == LEN_W'(1)) ? S_INS_FINAL : S_INS_ALLOC;
         S_INS_FINAL: state_in = S_IDLE;
         S_DEL_WALK: begin
            if (len_ff == '0) begin
               state_in = S_DEL_CHECK;
            end else if (child == '0) begin
               state_in = S_IDLE;
            end
         end
         S_DEL_CHECK: begin
            if (!view.holds || idx_ff == '0 || view.left != '0 || view.right != '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_PRUNE_UP;
            end
         end
         S_PRUNE_UP:   state_in = S_PRUNE_FREE;
         S_PRUNE_FREE: state_in = up_stops ? S_IDLE : S_PRUNE_UP;
         default:      state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      free_head_in   = free_head_ff;
      next_unused_in = next_unused_ff;
      count_in       = count_ff;
      root_in        = root_ff;
      key_in         = key_ff;
      len_in         = len_ff;
      val_in         = val_ff;
      depth_in       = depth_ff;
      idx_in         = idx_ff;
      par_idx_in     = par_idx_ff;
      up_idx_in      = up_idx_ff;
      new_idx_in     = new_idx_ff;
      par_in         = par_ff;
      up_in          = up_ff;
      found_in       = found_ff;
      fval_in        = fval_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      wr_req         = 1'b0;
      wr_idx         = '0;
      wr_rec         = par_ff;
      rd_en          = 1'b0;
      rd_addr        = child;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in   = req_tdata[31:0];
               len_in   = req_len;
               val_in   = req_tdata[69:38];
               depth_in = '0;
               idx_in   = '0;
               found_in = 1'b0;
               fval_in  = '0;
               if (func_type'(req_tuser) == FUNC_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_MISS;
                  rsp_found_in  = 1'b0;
                  rsp_value_in  = '0;
                  rsp_count_in  = count_ff;
               end
            end
         end
         S_LOOKUP: begin
            if (view.holds) begin
               found_in = 1'b1;
               fval_in  = view.value;
            end
            if (depth_ff == LEN_W'(MAX_LEN) || child == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_now ? STAT_OK : STAT_MISS;
               rsp_found_in  = found_now;
               rsp_value_in  = view.holds ? view.value : fval_ff;
               rsp_count_in  = count_ff;
            end else begin
               rd_en    = 1'b1;
               idx_in   = child;
               depth_in = depth_ff + LEN_W'(1);
               key_in   = key_ff << 1;
            end
         end
         S_INS_WALK: begin
            if (len_ff == '0 || child == '0) begin
               par_in     = view;
               par_idx_in = idx_ff;
            end else begin
               rd_en  = 1'b1;
               idx_in = child;
               len_in = len_ff - LEN_W'(1);
               key_in = key_ff << 1;
            end
         end
         S_INS_ALLOC: begin
            if (has_free) begin
               rd_en      = 1'b1;
               rd_addr    = free_head_ff;
               new_idx_in = free_head_ff;
            end else if (has_unused) begin
               new_idx_in     = next_unused_ff[IDX_W-1:0];
               next_unused_in = next_unused_ff + (IDX_W+1)'(1);
            end else begin
               // The last node made may exist only in par_ff; store it.
               wr_req        = 1'b1;
               wr_idx        = par_idx_ff;
               wr_rec        = par_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FULL;
               rsp_found_in  = 1'b0;
               rsp_value_in  = '0;
               rsp_count_in  = count_ff;
            end
         end
         S_INS_POP: begin
            free_head_in = rd_data.right;
         end
         S_INS_LINK: begin
            wr_req = 1'b1;
            wr_idx = par_idx_ff;
            wr_rec = par_ff;
            if (key_ff[KEY_W-1]) begin
               wr_rec.right = new_idx_ff;
            end else begin
               wr_rec.left = new_idx_ff;
            end
            par_in        = '0;
            par_in.parent = par_idx_ff;
            par_idx_in    = new_idx_ff;
            len_in        = len_ff - LEN_W'(1);
            key_in        = key_ff << 1;
         end
         S_INS_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b0;
            rsp_value_in = '0;
            if (par_ff.holds) begin
               rsp_status_in = STAT_DUP;
               rsp_count_in  = count_ff;
            end else begin
               wr_req        = 1'b1;
               wr_idx        = par_idx_ff;
               wr_rec        = par_ff;
               wr_rec.holds  = 1'b1;
               wr_rec.value  = val_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_status_in = STAT_OK;
               rsp_count_in  = count_ff + CNT_W'(1);
            end
         end
         S_DEL_WALK: begin
            if (len_ff != '0) begin
               if (child == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_MISS;
                  rsp_found_in  = 1'b0;
                  rsp_value_in  = '0;
                  rsp_count_in  = count_ff;
               end else begin
                  rd_en  = 1'b1;
                  idx_in = child;
                  len_in = len_ff - LEN_W'(1);
                  key_in = key_ff << 1;
               end
            end
         end
         S_DEL_CHECK: begin
            rsp_found_in = 1'b0;
            rsp_value_in = '0;
            if (!view.holds) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_MISS;
               rsp_count_in  = count_ff;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (idx_ff == '0 || view.left != '0 || view.right != '0) begin
                  wr_req        = 1'b1;
                  wr_idx        = idx_ff;
                  wr_rec        = view;
                  wr_rec.holds  = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_count_in  = count_ff - CNT_W'(1);
               end else begin
                  par_in       = view;
                  par_in.holds = 1'b0;
                  par_idx_in   = idx_ff;
                  up_idx_in    = view.parent;
                  rd_en        = 1'b1;
                  rd_addr      = view.parent;
               end
            end
         end
         S_PRUNE_UP: begin
            up_in = up_view;
            if (up_view.right == par_idx_ff) begin
               up_in.right = '0;
            end else begin
               up_in.left = '0;
            end
            wr_req = 1'b1;
            wr_idx = up_idx_ff;
            wr_rec = up_in;
         end
         S_PRUNE_FREE: begin
            wr_req       = 1'b1;
            wr_idx       = par_idx_ff;
            wr_rec       = par_ff;
            wr_rec.right = free_head_ff;
            free_head_in = par_idx_ff;
            if (up_stops) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_count_in  = count_ff;
            end else begin
               par_in     = up_ff;
               par_idx_in = up_idx_ff;
               up_idx_in  = up_ff.parent;
               rd_en      = 1'b1;
               rd_addr    = up_ff.parent;
            end
         end
         default: begin
         end
      endcase

      if (wr_req && wr_idx == '0) begin
         root_in = wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         free_head_ff   <= '0;
         next_unused_ff <= (IDX_W+1)'(1);
         count_ff       <= '0;
         root_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         next_unused_ff <= next_unused_in;
         count_ff       <= count_in;
         root_ff        <= root_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      len_ff        <= len_in;
      val_ff        <= val_in;
      depth_ff      <= depth_in;
      idx_ff        <= idx_in;
      par_idx_ff    <= par_idx_in;
      up_idx_ff     <= up_idx_in;
      new_idx_ff    <= new_idx_in;
      par_ff        <= par_in;
      up_ff         <= up_in;
      found_ff      <= found_in;
      fval_ff       <= fval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_value_ff, rsp_found_ff, rsp_status_ff};

   // The root is held in flip-flops and must never be written to memory.
   a_root_not_in_mem: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (wr_idx != '0))
      else $error("node memory write to root index");

   // An operation other than the unused code keeps the sequencer busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser != FUNC_NONE) |=> (state_ff != S_IDLE))
      else $error("operation accepted but sequencer stayed idle");

   // Free-list nodes were all handed out from fresh memory before.
   a_free_below_unused: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_head_ff} < next_unused_ff))
      else $error("free list head beyond allocated nodes");

   // Every stored prefix occupies its own node.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= next_unused_ff))
      else $error("prefix count exceeds allocated nodes");

endmodule
